// ===== src/sorted_deadline_timer_queue_assert.svh =====
// Assertion macros shared by the sorted deadline timer queue RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define SDTQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by another one.
`define SDTQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/sdtq_pkg.sv =====
// Package for the sorted deadline timer queue: transaction types, codes,
// controller states and the command and status bundles. No dependencies.
`default_nettype none

package sdtq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int TIME_BITS_DEF = 32;
    localparam int HANDLE_W      = 6;
    localparam int FIELD_TIME_W  = 32;
    localparam int MAX_POP       = 64;
    localparam int POP_W         = 7;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_ADJUST = 2'd1,
        FN_DELETE = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_EXPIRED   = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_PRESENT   = 2'd3
    } status_t;

    typedef struct packed {
        func_t                     func;
        logic [HANDLE_W-1:0]       handle;
        logic [FIELD_TIME_W-1:0]   expire_time;
        logic [FIELD_TIME_W-1:0]   now_time;
    } req_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]       out_handle;
        logic [FIELD_TIME_W-1:0]   out_expire;
        status_t                   status;
        logic                      last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        WR_NEW,
        WR_CARRY,
        WR_RDATA
    } wr_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_FIND_CHK,
        S_ADJ_RD,
        S_ADJ_CHK,
        S_RM,
        S_RM_WR,
        S_INS,
        S_INS_WR,
        S_T_RD0,
        S_T_CHK0,
        S_T_RD1,
        S_T_CHK1,
        S_T_EMIT,
        S_ERR
    } ctrl_state_t;

    typedef struct packed {
        logic    load_op;
        logic    rd_en;
        logic    rd_next;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    count_inc;
        logic    count_dec;
        logic    carry_ld;
        logic    hit_set;
        logic    head_ld;
        logic    more_ld;
        logic    more_clr;
        logic    pop_inc;
        logic    out_ld;
        status_t out_code;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  at_end;
        logic  next_end;
        logic  empty;
        logic  full;
        logic  hit;
        logic  match;
        logic  rd_later;
        logic  rd_due;
        logic  more;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/sdtq_ctrl.sv =====
// Controller state machine of the sorted deadline timer queue.
// Depends on sdtq_pkg; drives the datapath through dp_cmd_t only.
`default_nettype none

module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire func_t    req_func,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    status_t     err_reg;
    status_t     err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            err_reg   <= ST_FULL;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        err_next   = err_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_op = 1'b1;
                    state_next  = (req_func == FN_TICK) ? S_T_RD0 : S_FIND;
                end
            end
            S_FIND:
            begin
                if (stat.at_end)
                begin
                    if (stat.func != FN_INSERT)
                    begin
                        err_next   = ST_NOT_FOUND;
                        state_next = S_ERR;
                    end
                    else if (stat.full)
                    begin
                        err_next   = ST_FULL;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_INS;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (stat.match)
                begin
                    unique case (stat.func)
                        FN_INSERT:
                        begin
                            err_next   = ST_PRESENT;
                            state_next = S_ERR;
                        end
                        FN_ADJUST: state_next = S_ADJ_RD;
                        FN_DELETE: state_next = S_RM;
                        default:   state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_FIND;
                end
            end
            S_ADJ_RD:
            begin
                if (stat.next_end)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_NEW;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_ADJ_CHK;
                end
            end
            S_ADJ_CHK:
            begin
                if (stat.rd_later)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_NEW;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RM;
                end
            end
            S_RM:
            begin
                if (stat.next_end)
                begin
                    cmd.count_dec = 1'b1;
                    if (stat.func == FN_ADJUST)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_INS;
                    end
                    else if (stat.func == FN_TICK && stat.more)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_T_RD0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_RDATA;
                cmd.idx_inc = 1'b1;
                state_next  = S_RM;
            end
            S_INS:
            begin
                if (stat.at_end)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = stat.hit ? WR_CARRY : WR_NEW;
                    cmd.count_inc = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                if (stat.hit)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_CARRY;
                    cmd.carry_ld = 1'b1;
                end
                else if (stat.rd_later)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_NEW;
                    cmd.carry_ld = 1'b1;
                    cmd.hit_set  = 1'b1;
                end
                cmd.idx_inc = 1'b1;
                state_next  = S_INS;
            end
            S_T_RD0:
            begin
                if (stat.empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_T_CHK0;
                end
            end
            S_T_CHK0:
            begin
                if (stat.rd_due)
                begin
                    cmd.head_ld = 1'b1;
                    state_next  = S_T_RD1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_T_RD1:
            begin
                if (stat.next_end)
                begin
                    cmd.more_clr = 1'b1;
                    state_next   = S_T_EMIT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = S_T_CHK1;
                end
            end
            S_T_CHK1:
            begin
                cmd.more_ld = 1'b1;
                state_next  = S_T_EMIT;
            end
            S_T_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_code = ST_EXPIRED;
                    cmd.pop_inc  = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_RM;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_code = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sdtq_dpath.sv =====
// Datapath of the sorted deadline timer queue: slot memory, counters,
// operand and carry registers and the result register. Depends on sdtq_pkg.
`default_nettype none

module sdtq_dpath
    import sdtq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_item_t req,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

`include "sorted_deadline_timer_queue_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [HANDLE_W-1:0]  mem_handle [CAPACITY];
    logic [TIME_BITS-1:0] mem_expire [CAPACITY];

    func_t                op_func_reg;
    logic [HANDLE_W-1:0]  op_handle_reg;
    logic [TIME_BITS-1:0] op_expire_reg;
    logic [TIME_BITS-1:0] op_now_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [HANDLE_W-1:0]  carry_handle_reg;
    logic [TIME_BITS-1:0] carry_expire_reg;
    logic                 hit_reg;
    logic [HANDLE_W-1:0]  head_handle_reg;
    logic [TIME_BITS-1:0] head_expire_reg;
    logic                 more_reg;
    logic [POP_W-1:0]     pop_reg;
    logic [HANDLE_W-1:0]  rd_handle_reg;
    logic [TIME_BITS-1:0] rd_expire_reg;
    logic                 out_valid_reg;
    rsp_item_t            out_reg;
    rsp_item_t            out_next;

    logic [CNT_W-1:0]     idx_plus;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic [HANDLE_W-1:0]  wr_handle;
    logic [TIME_BITS-1:0] wr_expire;
    logic                 due_more;

    assign idx_plus = idx_reg + CNT_W'(1);
    assign rd_addr  = cmd.rd_next ? idx_plus[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_addr  = idx_reg[IDX_W-1:0];

    always_comb
    begin
        case (cmd.wr_sel)
            WR_CARRY:
            begin
                wr_handle = carry_handle_reg;
                wr_expire = carry_expire_reg;
            end
            WR_RDATA:
            begin
                wr_handle = rd_handle_reg;
                wr_expire = rd_expire_reg;
            end
            default:
            begin
                wr_handle = op_handle_reg;
                wr_expire = op_expire_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_handle[wr_addr] <= wr_handle;
            mem_expire[wr_addr] <= wr_expire;
        end
        if (cmd.rd_en)
        begin
            rd_handle_reg <= mem_handle[rd_addr];
            rd_expire_reg <= mem_expire[rd_addr];
        end
    end

    assign due_more = (rd_expire_reg <= op_now_reg) && (pop_reg < POP_W'(MAX_POP - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_func_reg   <= req.func;
            op_handle_reg <= req.handle;
            op_expire_reg <= TIME_BITS'(req.expire_time);
            op_now_reg    <= TIME_BITS'(req.now_time);
        end
        if (cmd.carry_ld)
        begin
            carry_handle_reg <= rd_handle_reg;
            carry_expire_reg <= rd_expire_reg;
        end
        if (cmd.head_ld)
        begin
            head_handle_reg <= rd_handle_reg;
            head_expire_reg <= rd_expire_reg;
        end
        if (cmd.out_ld)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            more_reg      <= 1'b0;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.load_op || cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_plus;
            end
            if (cmd.load_op)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmd.hit_set)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.more_clr)
            begin
                more_reg <= 1'b0;
            end
            else if (cmd.more_ld)
            begin
                more_reg <= due_more;
            end
            if (cmd.load_op)
            begin
                pop_reg <= '0;
            end
            else if (cmd.pop_inc)
            begin
                pop_reg <= pop_reg + POP_W'(1);
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next.status = cmd.out_code;
        if (cmd.out_code == ST_EXPIRED)
        begin
            out_next.out_handle = head_handle_reg;
            out_next.out_expire = FIELD_TIME_W'(head_expire_reg);
            out_next.last       = !more_reg;
        end
        else
        begin
            out_next.out_handle = op_handle_reg;
            out_next.out_expire = '0;
            out_next.last       = 1'b1;
        end
    end

    assign stat.func     = op_func_reg;
    assign stat.at_end   = (idx_reg == count_reg);
    assign stat.next_end = ((CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1))
                           >= (CNT_W + 1)'(count_reg);
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat.hit      = hit_reg;
    assign stat.match    = (rd_handle_reg == op_handle_reg);
    assign stat.rd_later = (rd_expire_reg > op_expire_reg);
    assign stat.rd_due   = (rd_expire_reg <= op_now_reg);
    assign stat.more     = more_reg;
    assign stat.out_free = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `SDTQ_ASSERT(a_out_load_free, !cmd.out_ld || !out_valid_reg || !rsp_stall, "result overwritten")
    `SDTQ_ASSERT(a_no_overfill, !cmd.count_inc || (count_reg < CNT_W'(CAPACITY)), "insert into full table")
    `SDTQ_ASSERT(a_no_underflow, !cmd.count_dec || (count_reg != '0), "removal from empty table")
    `SDTQ_ASSERT_NEXT(a_count_grows, cmd.count_inc, count_reg != '0, "count did not grow")

endmodule

`default_nettype wire

// ===== src/sorted_deadline_timer_queue.sv =====
// A sorted timer list of up to CAPACITY entries held in one memory in ascending expiry order.
// Every operation walks the memory one entry at a time: a lookup reads each entry up to the
// handle, an insert each entry of the list, a delete each entry behind the removed one, a move
// the entry behind it and, if it moves back, those of a delete and an insert, and each tick
// pop reads the head and the entry behind it, then shifts the rest of the list up. The single
// read and write port of the slot memory sets this.
// Requests are taken only while no earlier request is still in progress; a finished result
// waits in the output register without holding up the next request.
`default_nettype none

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     busy;

    assign req_stall = busy;

    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req.func),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    sdtq_dpath #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the sorted deadline timer queue: drives random and directed timer
// requests, predicts the expiry and error transactions and checks them in order.
// Depends on sdtq_pkg and the sorted_deadline_timer_queue RTL.
`timescale 1ns / 1ps

module testbench;
    import sdtq_pkg::*;

    class timer_scoreboard;
        logic [5:0]  list_handle[$];
        logic [31:0] list_expire[$];
        rsp_item_t   pending[$];
        int          mismatches;

        function int find_pos(logic [5:0] h);
            foreach (list_handle[i])
                if (list_handle[i] == h)
                    return i;
            return -1;
        endfunction

        function void place(logic [5:0] h, logic [31:0] e);
            int pos;
            pos = 0;
            while (pos < list_expire.size() && list_expire[pos] <= e)
                pos++;
            list_handle.insert(pos, h);
            list_expire.insert(pos, e);
        endfunction

        function void push_result(logic [5:0] h, logic [31:0] e, status_t s, logic l);
            rsp_item_t r;
            r.out_handle = h;
            r.out_expire = e;
            r.status = s;
            r.last = l;
            pending.push_back(r);
        endfunction

        function void note_request(req_item_t q);
            int idx;
            int n;
            case (q.func)
                FN_INSERT:
                begin
                    if (find_pos(q.handle) >= 0)
                        push_result(q.handle, 0, ST_PRESENT, 1'b1);
                    else if (list_handle.size() >= CAPACITY_DEF)
                        push_result(q.handle, 0, ST_FULL, 1'b1);
                    else
                        place(q.handle, q.expire_time);
                end
                FN_ADJUST:
                begin
                    idx = find_pos(q.handle);
                    if (idx < 0)
                        push_result(q.handle, 0, ST_NOT_FOUND, 1'b1);
                    else
                    begin
                        list_expire[idx] = q.expire_time;
                        if (idx + 1 < list_expire.size()
                            && q.expire_time >= list_expire[idx + 1])
                        begin
                            list_handle.delete(idx);
                            list_expire.delete(idx);
                            place(q.handle, q.expire_time);
                        end
                    end
                end
                FN_DELETE:
                begin
                    idx = find_pos(q.handle);
                    if (idx < 0)
                        push_result(q.handle, 0, ST_NOT_FOUND, 1'b1);
                    else
                    begin
                        list_handle.delete(idx);
                        list_expire.delete(idx);
                    end
                end
                default:
                begin
                    n = 0;
                    while (n < MAX_POP && list_expire.size() > 0
                           && list_expire[0] <= q.now_time)
                    begin
                        push_result(list_handle[0], list_expire[0], ST_EXPIRED, 1'b0);
                        void'(list_handle.pop_front());
                        void'(list_expire.pop_front());
                        n++;
                    end
                    if (n > 0)
                        pending[pending.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    timer_scoreboard sb;
    int   idle_cycles;
    int   next_gap;
    int   rsp_wait;
    int   rsp_draw;
    logic [31:0] clock_now;

    sorted_deadline_timer_queue dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 60000)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_wait <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            rsp_draw = $urandom_range(0, 13);
            rsp_wait <= rsp_draw;
            rsp_stall <= (rsp_draw != 0);
        end
        else if (rsp_wait > 1)
            rsp_wait <= rsp_wait - 1;
        else
        begin
            rsp_wait <= 0;
            rsp_stall <= 1'b0;
        end
    end

    task automatic send(func_t f, logic [5:0] h, logic [31:0] e, logic [31:0] n);
        repeat (next_gap) @(posedge clk);
        req_valid <= 1'b1;
        req.func <= f;
        req.handle <= h;
        req.expire_time <= e;
        req.now_time <= n;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request('{f, h, e, n});
        next_gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            next_gap = 0;
        if (next_gap != 0)
            req_valid <= 1'b0;
    endtask

    task automatic send_random();
        int pick;
        logic [5:0]  h;
        logic [31:0] e;
        pick = $urandom_range(0, 99);
        h = (sb.list_handle.size() > 0 && $urandom_range(0, 2) != 0)
            ? sb.list_handle[$urandom_range(0, sb.list_handle.size() - 1)]
            : 6'($urandom_range(0, 63));
        e = ($urandom_range(0, 9) == 0) ? $urandom
            : clock_now + $urandom_range(0, 40);
        if (pick < 40)
            send(FN_INSERT, h, e, $urandom);
        else if (pick < 58)
            send(FN_ADJUST, h, e, $urandom);
        else if (pick < 72)
            send(FN_DELETE, h, $urandom, $urandom);
        else
        begin
            clock_now = clock_now + $urandom_range(0, 12);
            send(FN_TICK, 6'($urandom), $urandom, clock_now);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        idle_cycles = 0;
        next_gap = 0;
        clock_now = 32'd100;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(FN_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
        send(FN_DELETE, 6'd5, 32'd0, 32'd0);
        send(FN_ADJUST, 6'd63, 32'd0, 32'd0);
        send(FN_INSERT, 6'd0, 32'hFFFF_FFFF, 32'd0);
        send(FN_INSERT, 6'd63, 32'd0, 32'hFFFF_FFFF);
        send(FN_INSERT, 6'd10, 32'd50, 32'd0);
        send(FN_INSERT, 6'd11, 32'd50, 32'd0);
        send(FN_INSERT, 6'd10, 32'd7, 32'd0);
        send(FN_ADJUST, 6'd10, 32'd50, 32'd0);
        send(FN_ADJUST, 6'd63, 32'd60, 32'd0);
        send(FN_ADJUST, 6'd0, 32'd1, 32'd0);
        send(FN_TICK, 6'd0, 32'd0, 32'd0);
        send(FN_TICK, 6'd0, 32'd0, 32'd55);
        send(FN_DELETE, 6'd0, 32'd0, 32'd0);
        send(FN_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 64; i++)
            send(FN_INSERT, 6'(i), 32'(i % 5), 32'd0);
        send(FN_INSERT, 6'd3, 32'd9, 32'd0);
        for (int i = 0; i < 64; i++)
            if (i != 20)
                send(FN_DELETE, 6'(i), 32'd0, 32'd0);
        send(FN_INSERT, 6'd21, 32'd1, 32'd0);
        send(FN_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);

        for (int i = 0; i < 334; i++)
            send_random();
        send(FN_TICK, 6'd0, 32'd0, 32'hFFFF_FFFF);
        if (next_gap == 0)
            req_valid <= 1'b0;

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/sdtq_pkg.sv
src/sdtq_ctrl.sv
src/sdtq_dpath.sv
src/sorted_deadline_timer_queue.sv
tb/sv/testbench.sv
